[rtl/srtf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srtf_pkg: shared types and constants of the srtf scheduler
// slot table geometry, time width, cell control and scan candidate types
// ---------------------------------------------------------------------------
package srtf_pkg;

    localparam int SLOTS        = 16;
    localparam int TIME_BITS    = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_FIELD_W = 16;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef logic [TIME_BITS-1:0]    t_time;
    typedef logic [SLOT_W-1:0]       t_slot_idx;
    typedef logic [SLOT_FIELD_W-1:0] t_slot_field;
    typedef logic [TIME_FIELD_W-1:0] t_time_field;

    localparam t_time     TIME_MAX = {TIME_BITS{1'b1}};
    localparam t_slot_idx CNT_LAST = SLOT_W'(SLOTS - 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // best slot found so far as it walks along the chain
    typedef struct packed {
        logic      found;
        t_slot_idx idx;
        t_time     rem;
        t_time     arr;
        t_time     svc;
    } t_cand;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic      load;
        logic      dec;
        t_slot_idx sel;
        t_time     arr;
        t_time     burst;
    } t_cell_ctrl;

    function automatic t_time time_from_field(input t_time_field f);
        logic [47:0] w;
        w = {32'b0, f};
        return w[TIME_BITS-1:0];
    endfunction

    function automatic t_time_field time_to_field(input t_time t);
        logic [47:0] w;
        w = 48'(t);
        return w[TIME_FIELD_W-1:0];
    endfunction

    function automatic t_slot_idx slot_from_field(input t_slot_field f);
        logic [15:0] w;
        w = {12'b0, f};
        return w[SLOT_W-1:0];
    endfunction

    function automatic t_slot_field slot_to_field(input t_slot_idx s);
        logic [15:0] w;
        w = 16'(s);
        return w[SLOT_FIELD_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/srtf_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srtf_in_if / srtf_out_if: valid-ready channels of the srtf scheduler
// request channel (load or tick) and result channel (one result per tick)
// ---------------------------------------------------------------------------
interface srtf_in_if import srtf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        func;
    t_slot_field slot;
    t_time_field arrival;
    t_time_field burst;

    modport source (output valid, func, slot, arrival, burst, input ready);
    modport sink   (input valid, func, slot, arrival, burst, output ready);
endinterface

interface srtf_out_if import srtf_pkg::*; ();
    logic        valid;
    logic        ready;
    t_slot_field run_slot;
    logic        idle;
    logic        finished;
    t_time_field finish_time;
    t_time_field turnaround;
    t_time_field waiting;

    modport source (output valid, run_slot, idle, finished, finish_time, turnaround,
                    waiting, input ready);
    modport sink   (input valid, run_slot, idle, finished, finish_time, turnaround,
                    waiting, output ready);
endinterface
`default_nettype wire

[rtl/srtf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srtf_cell: one task slot of the scheduler chain
// holds the slot's remaining time, arrival and burst, and registers the
// better of its own slot and the candidate coming from its left neighbour
// ---------------------------------------------------------------------------
module srtf_cell import srtf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_slot_idx  i_idx,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_time      i_clock_now,
    input  wire t_cand      i_cand,
    output t_cand           o_cand
);

    t_time r_rem, n_rem;
    t_time r_arr;
    t_time r_svc;
    t_cand r_cand, n_cand;
    logic  hit;
    logic  eligible;
    logic  take;

    assign hit = (i_ctrl.sel == i_idx);

    always_comb begin
        n_rem = r_rem;
        if (i_ctrl.load && hit) begin
            n_rem = i_ctrl.burst;
        end else if (i_ctrl.dec && hit) begin
            n_rem = r_rem - t_time'(1);
        end
    end

    // strict compares keep the lower slot on a full tie
    assign eligible = (r_rem != '0) && (r_arr <= i_clock_now);
    assign take     = eligible && (!i_cand.found || (r_rem < i_cand.rem) ||
                      ((r_rem == i_cand.rem) && (r_arr < i_cand.arr)));

    always_comb begin
        n_cand = i_cand;
        if (take) begin
            n_cand = '{found: 1'b1, idx: i_idx, rem: r_rem, arr: r_arr, svc: r_svc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_cand <= '0;
        end else begin
            r_rem  <= n_rem;
            r_cand <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && hit) begin
            r_arr <= i_ctrl.arr;
            r_svc <= i_ctrl.burst;
        end
    end

    assign o_cand = r_cand;

endmodule
`default_nettype wire

[rtl/srtf_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srtf_scheduler: shortest-remaining-time-first scheduler over a slot table
// loads tasks into slots and serves one slot per tick, reporting completions
// ---------------------------------------------------------------------------
// A load (func 0) writes a slot and is ignored for a slot beyond the table.
// A tick (func 1) keeps the request channel closed while it scans: the
// slots sit in a chain of SLOTS cells and the best candidate moves one
// cell per cycle from slot 0 upwards; once it has passed the last cell the
// served slot is decremented, the time advances (saturating) and one
// result is written to the output register.
// The result register lets loads be taken while a result waits for its
// transfer; a tick whose scan finishes before the previous result has gone
// holds until the output register frees up. Remaining times reset to zero;
// arrival and burst of a slot are only meaningful once it has been loaded.
// ---------------------------------------------------------------------------
module srtf_scheduler import srtf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srtf_in_if.sink     i_in,
    srtf_out_if.source  o_out
);

    // control
    t_state    r_state, n_state;
    t_slot_idx r_cnt, n_cnt;
    t_time     r_clock;
    logic      r_out_valid;

    // result payload
    t_slot_field r_run_slot;
    logic        r_idle;
    logic        r_finished;
    t_time_field r_finish_time;
    t_time_field r_turnaround;
    t_time_field r_waiting;

    logic       in_xfer;
    logic       out_xfer;
    logic       commit;
    logic       slot_ok;
    t_cell_ctrl ctrl;
    t_cand      chain [SLOTS+1];
    t_cand      win;
    t_time      clock_inc;
    t_time      tat;
    t_time      wt;
    logic       done;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    // slot field may be wider than the table index
    assign slot_ok = (32'(i_in.slot) < 32'(SLOTS));

    // commit once the candidate has passed the last cell and the result slot is free
    assign commit = (r_state == S_SCAN) && (r_cnt == CNT_LAST) &&
                    (!r_out_valid || o_out.ready);

    // ---- fsm ----
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (in_xfer && (i_in.func == FUNC_TICK)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CNT_LAST) begin
                    n_cnt = r_cnt + t_slot_idx'(1);
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // ---- cell commands: a load and a commit never meet in one cycle ----
    always_comb begin
        ctrl.load  = in_xfer && (i_in.func == FUNC_LOAD) && slot_ok;
        ctrl.dec   = commit && win.found;
        ctrl.sel   = ctrl.load ? slot_from_field(i_in.slot) : win.idx;
        ctrl.arr   = time_from_field(i_in.arrival);
        ctrl.burst = time_from_field(i_in.burst);
    end

    // ---- the chain of slot cells ----
    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        srtf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (t_slot_idx'(g)),
            .i_ctrl      (ctrl),
            .i_clock_now (r_clock),
            .i_cand      (chain[g]),
            .o_cand      (chain[g+1])
        );
    end

    assign win = chain[SLOTS];

    // ---- completion arithmetic ----
    assign clock_inc = (r_clock == TIME_MAX) ? r_clock : r_clock + t_time'(1);
    assign done      = win.found && (win.rem == t_time'(1));
    // served slot arrived at or before the current time, so no wrap here
    assign tat       = clock_inc - win.arr;
    // only negative after the clock has saturated: clamp at zero
    assign wt        = (tat >= win.svc) ? tat - win.svc : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_clock     <= clock_inc;
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_run_slot    <= win.found ? slot_to_field(win.idx) : '0;
            r_idle        <= !win.found;
            r_finished    <= done;
            r_finish_time <= done ? time_to_field(clock_inc) : '0;
            r_turnaround  <= done ? time_to_field(tat) : '0;
            r_waiting     <= done ? time_to_field(wt) : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.run_slot    = r_run_slot;
    assign o_out.idle        = r_idle;
    assign o_out.finished    = r_finished;
    assign o_out.finish_time = r_finish_time;
    assign o_out.turnaround  = r_turnaround;
    assign o_out.waiting     = r_waiting;

endmodule
`default_nettype wire

[rtl/srtf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srtf_checker: port-level assertions for the srtf scheduler
// watches both channels of the top level; attached by a bind statement
// ---------------------------------------------------------------------------
module srtf_checker import srtf_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_func,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire t_slot_field i_run_slot,
    input wire logic        i_idle,
    input wire logic        i_finished,
    input wire t_time_field i_finish_time,
    input wire t_time_field i_turnaround,
    input wire t_time_field i_waiting
);

    // a pending result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    // a tick keeps the request channel closed while the slots are scanned
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_func == FUNC_TICK)) |=> !i_in_ready)
        else $error("request taken during a scan");

    // an idle tick reports nothing else
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_idle) |-> ((i_run_slot == '0) && !i_finished &&
        (i_finish_time == '0) && (i_turnaround == '0) && (i_waiting == '0)))
        else $error("idle result carries data");

    // a completion comes from a served slot and its times are ordered
    a_finish_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_finished) |-> (!i_idle && (i_waiting <= i_turnaround) &&
        (i_turnaround <= i_finish_time)))
        else $error("inconsistent completion times");

endmodule

bind srtf_scheduler srtf_checker u_srtf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_func     (i_in.func),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_run_slot    (o_out.run_slot),
    .i_idle        (o_out.idle),
    .i_finished    (o_out.finished),
    .i_finish_time (o_out.finish_time),
    .i_turnaround  (o_out.turnaround),
    .i_waiting     (o_out.waiting)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the srtf scheduler
// random and directed loads and ticks go in over the request channel, an
// in-bench scheduler model predicts each tick result, and every result
// transfer is checked field by field under varying idle and stall patterns
// ---------------------------------------------------------------------------
module testbench;
    import srtf_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 240;

    typedef struct packed {
        logic        func;
        t_slot_field slot;
        t_time_field arrival;
        t_time_field burst;
    } sched_req_t;

    typedef struct packed {
        t_slot_field run_slot;
        logic        idle;
        logic        finished;
        t_time_field finish_time;
        t_time_field turnaround;
        t_time_field waiting;
    } sched_res_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    srtf_in_if  req_ch ();
    srtf_out_if res_ch ();

    srtf_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // scheduler model state, own copy of the slot table and the time
    t_time task_left    [SLOTS] = '{default: '0};
    t_time task_arrival [SLOTS] = '{default: '0};
    t_time task_burst   [SLOTS] = '{default: '0};
    t_time sched_clock          = '0;

    sched_req_t pending_reqs [$];
    sched_res_t tick_results [$];

    // counters; the accepted and result counts move by nonblocking update
    int queued_count   = 0;
    int accepted_count = 0;
    int results_due    = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int gen_clock      = 0;   // time the stimulus expects the block to be at

    // idle and stall odds in percent, plus the long receiver hold-off
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_arm       = 1'b0;
    int hold_count     = 0;
    bit in_taken       = 1'b0;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // one scheduler step: a load updates the table, a tick returns a result
    function automatic bit srtf_step(input sched_req_t req, output sched_res_t res);
        t_slot_idx pick;
        bit        found;
        t_time     tat;
        res   = '0;
        pick  = '0;
        found = 1'b0;
        if (req.func == FUNC_LOAD) begin
            if (int'(req.slot) < SLOTS) begin
                task_arrival[t_slot_idx'(req.slot)] = t_time'(req.arrival);
                task_burst[t_slot_idx'(req.slot)]   = t_time'(req.burst);
                task_left[t_slot_idx'(req.slot)]    = t_time'(req.burst);
            end
            return 1'b0;
        end
        // least remaining work wins, then earlier arrival, then lower slot
        for (int i = 0; i < SLOTS; i++) begin
            if (task_left[i] != '0 && task_arrival[i] <= sched_clock) begin
                if (!found || task_left[i] < task_left[pick] ||
                    (task_left[i] == task_left[pick] &&
                     task_arrival[i] < task_arrival[pick])) begin
                    pick  = t_slot_idx'(i);
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            task_left[pick] = task_left[pick] - 1'b1;
        end
        // time saturates at the top of its range
        if (sched_clock != TIME_MAX) begin
            sched_clock = sched_clock + 1'b1;
        end
        res.idle = !found;
        if (found) begin
            res.run_slot = t_slot_field'(pick);
            if (task_left[pick] == '0) begin
                tat             = sched_clock - task_arrival[pick];
                res.finished    = 1'b1;
                res.finish_time = t_time_field'(sched_clock);
                res.turnaround  = t_time_field'(tat);
                // only a saturated clock can make this negative; clamp to zero
                res.waiting     = (tat >= task_burst[pick]) ?
                                  t_time_field'(tat - task_burst[pick]) : '0;
            end
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // request side: accepted transfers feed the model, result side is checked
    always @(posedge i_clk) begin
        sched_req_t acc_req;
        sched_res_t want_res;
        sched_res_t got_res;
        in_taken <= i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            acc_req.func    = req_ch.func;
            acc_req.slot    = req_ch.slot;
            acc_req.arrival = req_ch.arrival;
            acc_req.burst   = req_ch.burst;
            accepted_count <= accepted_count + 1;
            if (srtf_step(acc_req, want_res)) begin
                tick_results = {tick_results, want_res};
                results_due <= results_due + 1;
            end
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_res.run_slot    = res_ch.run_slot;
            got_res.idle        = res_ch.idle;
            got_res.finished    = res_ch.finished;
            got_res.finish_time = res_ch.finish_time;
            got_res.turnaround  = res_ch.turnaround;
            got_res.waiting     = res_ch.waiting;
            if (tick_results.size() == 0) begin
                fail_count++;
                $display("%0t: result transfer with no tick pending, expected none, actual %h",
                         $time, got_res);
            end else begin
                want_res = tick_results.pop_front();
                results_seen <= results_seen + 1;
                check_field("run_slot", want_res.run_slot, got_res.run_slot);
                check_field("idle", want_res.idle, got_res.idle);
                check_field("finished", want_res.finished, got_res.finished);
                check_field("finish_time", want_res.finish_time, got_res.finish_time);
                check_field("turnaround", want_res.turnaround, got_res.turnaround);
                check_field("waiting", want_res.waiting, got_res.waiting);
            end
        end
    end

    // request driver: a new item only once the previous one has transferred
    always @(negedge i_clk) begin
        sched_req_t next_req;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || in_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_reqs.pop_front();
                req_ch.valid   <= 1'b1;
                req_ch.func    <= next_req.func;
                req_ch.slot    <= next_req.slot;
                req_ch.arrival <= next_req.arrival;
                req_ch.burst   <= next_req.burst;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here once armed
    always @(negedge i_clk) begin
        if (hold_arm && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end

    // result receiver with random stalls
    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && !(hold_arm && hold_count < HOLD_CYCLES) &&
                        ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_load(input int slot, input int arrival, input int burst);
        sched_req_t req;
        req.func    = FUNC_LOAD;
        req.slot    = t_slot_field'(slot);
        req.arrival = t_time_field'(arrival);
        req.burst   = t_time_field'(burst);
        pending_reqs = {pending_reqs, req};
        queued_count++;
    endtask

    // ticks carry junk in the unused fields
    task automatic queue_ticks(input int count);
        sched_req_t req;
        repeat (count) begin
            req.func    = FUNC_TICK;
            req.slot    = t_slot_field'($urandom_range(15));
            req.arrival = t_time_field'($urandom);
            req.burst   = t_time_field'($urandom);
            pending_reqs = {pending_reqs, req};
            queued_count++;
            if (gen_clock < int'(TIME_MAX)) begin
                gen_clock++;
            end
        end
    endtask

    // mostly task sets that arrive around now and run to completion,
    // with stray loads of any value and loose ticks mixed in
    task automatic queue_random_traffic(input int count);
        int stop_at;
        int n_tasks;
        int burst;
        int offset;
        int arrival;
        int work;
        stop_at = queued_count + count;
        while (queued_count < stop_at) begin
            if ($urandom_range(9) < 8) begin
                n_tasks = $urandom_range(1, 5);
                work    = 0;
                repeat (n_tasks) begin
                    burst   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
                    offset  = $urandom_range(8);
                    arrival = gen_clock + offset - 3;
                    if (arrival < 0) begin
                        arrival = 0;
                    end
                    queue_load($urandom_range(15), arrival, burst);
                    work += burst;
                    if ($urandom_range(3) == 0) begin
                        queue_ticks(1);
                    end
                end
                queue_ticks(work + $urandom_range(4));
            end else if ($urandom_range(1) == 0) begin
                queue_load($urandom_range(15), $urandom_range(65535), $urandom_range(65535));
            end else begin
                queue_ticks($urandom_range(1, 4));
            end
        end
    endtask

    task automatic wait_all_taken();
        while (accepted_count != queued_count) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_LOAD;
        req_ch.slot    = '0;
        req_ch.arrival = '0;
        req_ch.burst   = '0;
        res_ch.ready   = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, ties, zero burst, far future task, reload
        queue_ticks(1);
        queue_load(0, 0, 3);
        queue_load(15, 0, 2);
        queue_load(4, 1, 2);
        queue_load(9, 2, 1);
        queue_load(6, 0, 0);
        queue_load(1, 65535, 65535);
        queue_ticks(6);
        queue_load(10, gen_clock, 2);
        queue_load(11, gen_clock, 2);
        queue_load(0, 3, 4);
        queue_load(12, 0, 1);
        queue_ticks(5);
        wait_all_taken();

        // random traffic under four idle patterns; the first one also holds
        // the receiver off for a long stretch so the block backs up
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_arm       = 1'b1;
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            queue_random_traffic(PHASE_ITEMS);
            wait_all_taken();
        end

        // cleared table, then equal remaining work split by arrival and slot
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        for (int s = 0; s < SLOTS; s++) begin
            queue_load(s, 0, 0);
        end
        queue_load(3, gen_clock, 2);
        queue_load(5, gen_clock - 5, 1);
        queue_load(7, gen_clock, 1);
        queue_load(2, gen_clock, 1);
        queue_ticks(6);

        while (accepted_count != queued_count || results_due != results_seen) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due == results_seen) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
